// ===== src/pida_pkg.sv =====
// Shared types and constants for the positional insert/delete array.
// No dependencies; used by every module of the block.
`default_nettype none

package pida_pkg;

  localparam int CAPACITY     = 64;
  localparam int ELEMENT_BITS = 32;
  localparam int IDX_BITS     = $clog2(CAPACITY);
  localparam int CNT_BITS     = 7;
  localparam int POS_BITS     = 7;
  localparam int VALUE_BITS   = 32;
  localparam int CMD_BITS     = 3;
  localparam int STATUS_BITS  = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_READ    = 3'd0,
    CMD_REPLACE = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_APPEND  = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [IDX_BITS-1:0]     tgt;
    logic [ELEMENT_BITS-1:0] data;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/pida_cell.sv =====
// One storage cell of the element chain: holds one element and takes
// a new value from the broadcast command or from either neighbour.
// Depends on pida_pkg.
`default_nettype none

module pida_cell (
  input  wire logic                                clk,
  input  wire logic [pida_pkg::IDX_BITS-1:0]       idx,
  input  wire pida_pkg::cell_cmd_t                 cmd,
  input  wire logic [pida_pkg::ELEMENT_BITS-1:0]   left_data,
  input  wire logic [pida_pkg::ELEMENT_BITS-1:0]   right_data,
  output logic      [pida_pkg::ELEMENT_BITS-1:0]   data
);

  logic [pida_pkg::ELEMENT_BITS-1:0] data_r;
  logic [pida_pkg::ELEMENT_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      pida_pkg::CELL_WRITE: begin
        if (idx == cmd.tgt) data_nxt = cmd.data;
      end
      pida_pkg::CELL_INSERT: begin
        if (idx == cmd.tgt) data_nxt = cmd.data;
        else if (idx > cmd.tgt) data_nxt = left_data;
      end
      pida_pkg::CELL_DELETE: begin
        if (idx >= cmd.tgt) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== src/pida_ctrl.sv =====
// Command decode, range and full checks, element count and result
// length/status registers. Depends on pida_pkg.
`default_nettype none

module pida_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                accept,
  input  wire logic [pida_pkg::CMD_BITS-1:0]       command,
  input  wire logic [pida_pkg::POS_BITS-1:0]       position,
  input  wire logic [pida_pkg::VALUE_BITS-1:0]     value,
  output pida_pkg::cell_cmd_t                      cell_cmd,
  output logic                                     read_ok,
  output logic                                     res_valid,
  output logic      [pida_pkg::CNT_BITS-1:0]       res_length,
  output logic      [pida_pkg::STATUS_BITS-1:0]    res_status
);

  localparam logic [pida_pkg::CNT_BITS-1:0] CAP = pida_pkg::CNT_BITS'(pida_pkg::CAPACITY);

  logic [pida_pkg::CNT_BITS-1:0]    count_r, count_nxt;
  logic                             valid_r;
  logic [pida_pkg::STATUS_BITS-1:0] status_r;
  logic [pida_pkg::CNT_BITS-1:0]    length_r;
  pida_pkg::status_t                status;
  logic                             in_range;
  logic                             full;
  logic [pida_pkg::CNT_BITS-1:0]    pos_w;

  assign pos_w    = pida_pkg::CNT_BITS'(position);
  assign in_range = (pos_w < count_r);
  assign full     = (count_r >= CAP);

  always_comb begin
    count_nxt     = count_r;
    status        = pida_pkg::ST_OK;
    read_ok       = 1'b0;
    cell_cmd.op   = pida_pkg::CELL_HOLD;
    cell_cmd.tgt  = position[pida_pkg::IDX_BITS-1:0];
    cell_cmd.data = pida_pkg::ELEMENT_BITS'(value);
    unique case (command)
      pida_pkg::CMD_READ: begin
        if (in_range) read_ok = 1'b1;
        else status = pida_pkg::ST_RANGE;
      end
      pida_pkg::CMD_REPLACE: begin
        if (in_range) cell_cmd.op = pida_pkg::CELL_WRITE;
        else status = pida_pkg::ST_RANGE;
      end
      pida_pkg::CMD_INSERT: begin
        if (pos_w > count_r) begin
          status = pida_pkg::ST_RANGE;
        end else if (full) begin
          status = pida_pkg::ST_FULL;
        end else begin
          cell_cmd.op = pida_pkg::CELL_INSERT;
          count_nxt   = count_r + 1'b1;
        end
      end
      pida_pkg::CMD_APPEND: begin
        cell_cmd.tgt = count_r[pida_pkg::IDX_BITS-1:0];
        if (full) begin
          status = pida_pkg::ST_FULL;
        end else begin
          cell_cmd.op = pida_pkg::CELL_WRITE;
          count_nxt   = count_r + 1'b1;
        end
      end
      pida_pkg::CMD_DELETE: begin
        if (in_range) begin
          cell_cmd.op = pida_pkg::CELL_DELETE;
          count_nxt   = count_r - 1'b1;
        end else begin
          status = pida_pkg::ST_RANGE;
        end
      end
      default: status = pida_pkg::ST_OK;
    endcase
    if (!accept) begin
      cell_cmd.op = pida_pkg::CELL_HOLD;
      count_nxt   = count_r;
      read_ok     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      length_r <= count_nxt;
      status_r <= status;
    end
  end

  assign res_valid  = valid_r;
  assign res_length = length_r;
  assign res_status = status_r;

endmodule

`default_nettype wire

// ===== src/positional_insert_delete_array_top.sv =====
// Top level of the positional insert/delete array: control plus a chain of
// element cells. Depends on pida_pkg, pida_ctrl and pida_cell.
// The result strobe is registered and rises in the cycle after the command transfer.
// Throughput: one command per cycle; busy stays low, every cell shifts in parallel.
// Reset: synchronous, active low; clears the element count and the result strobe.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module positional_insert_delete_array_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [pida_pkg::CMD_BITS-1:0]       in_command,
  input  wire logic [pida_pkg::POS_BITS-1:0]       in_position,
  input  wire logic [pida_pkg::VALUE_BITS-1:0]     in_value,
  output logic                                     out_valid,
  output logic      [pida_pkg::VALUE_BITS-1:0]     out_read_value,
  output logic      [pida_pkg::CNT_BITS-1:0]       out_length,
  output logic      [pida_pkg::STATUS_BITS-1:0]    out_status
);

  logic                              accept;
  pida_pkg::cell_cmd_t               cell_cmd;
  logic                              read_ok;
  logic [pida_pkg::ELEMENT_BITS-1:0] cell_data [pida_pkg::CAPACITY];
  logic [pida_pkg::ELEMENT_BITS-1:0] read_value_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  pida_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .position   (in_position),
    .value      (in_value),
    .cell_cmd   (cell_cmd),
    .read_ok    (read_ok),
    .res_valid  (out_valid),
    .res_length (out_length),
    .res_status (out_status)
  );

  for (genvar g = 0; g < pida_pkg::CAPACITY; g++) begin : g_cell
    logic [pida_pkg::ELEMENT_BITS-1:0] left_w;
    logic [pida_pkg::ELEMENT_BITS-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[g-1];
    end

    if (g == pida_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[g+1];
    end

    pida_cell u_cell (
      .clk        (clk),
      .idx        (pida_pkg::IDX_BITS'(g)),
      .cmd        (cell_cmd),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_r <= read_ok ? cell_data[in_position[pida_pkg::IDX_BITS-1:0]] : '0;
    end
  end

  assign out_read_value = pida_pkg::VALUE_BITS'(read_value_r);

endmodule

`default_nettype wire

// ===== bench/positional_insert_delete_array_top_test.sv =====
// Testbench for positional_insert_delete_array_top: directed and random command streams,
// checked result by result against a shadow list kept in the bench.
// Depends on pida_pkg and the RTL of the block.
`default_nettype none

module positional_insert_delete_array_top_test;

  localparam logic [pida_pkg::CMD_BITS-1:0]   CMD_UNUSED_A = 3'd5;
  localparam logic [pida_pkg::CMD_BITS-1:0]   CMD_UNUSED_B = 3'd6;
  localparam logic [pida_pkg::CMD_BITS-1:0]   CMD_UNUSED_C = 3'd7;
  localparam logic [pida_pkg::POS_BITS-1:0]   POS_TOP      = {pida_pkg::POS_BITS{1'b1}};
  localparam logic [pida_pkg::VALUE_BITS-1:0] VAL_ONES     = {pida_pkg::VALUE_BITS{1'b1}};
  localparam int RANDOM_ITEMS = 1750;
  localparam int BLOCK_ITEMS  = 150;

  typedef struct {
    logic [pida_pkg::VALUE_BITS-1:0] read_value;
    logic [pida_pkg::CNT_BITS-1:0]   length;
    pida_pkg::status_t               status;
  } list_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic [pida_pkg::CMD_BITS-1:0]    in_command = '0;
  logic [pida_pkg::POS_BITS-1:0]    in_position = '0;
  logic [pida_pkg::VALUE_BITS-1:0]  in_value = '0;
  logic                             out_valid;
  logic [pida_pkg::VALUE_BITS-1:0]  out_read_value;
  logic [pida_pkg::CNT_BITS-1:0]    out_length;
  logic [pida_pkg::STATUS_BITS-1:0] out_status;

  logic [pida_pkg::ELEMENT_BITS-1:0] shadow_list [pida_pkg::CAPACITY];
  int unsigned                       shadow_count = 0;
  list_result_t                      pending_results [$];
  int unsigned                       error_count = 0;
  int unsigned                       gap_max = 15;

  positional_insert_delete_array_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .out_status     (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("positional_insert_delete_array_top_test: done, errors");
    $finish;
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic apply_to_shadow_list(input logic [pida_pkg::CMD_BITS-1:0] cmd,
                                      input logic [pida_pkg::POS_BITS-1:0] pos,
                                      input logic [pida_pkg::VALUE_BITS-1:0] val);
    list_result_t r;
    int unsigned  p;
    p = pos;
    r.read_value = '0;
    r.status = pida_pkg::ST_OK;
    case (cmd)
      pida_pkg::CMD_READ: begin
        if (p < shadow_count) r.read_value = shadow_list[p];
        else r.status = pida_pkg::ST_RANGE;
      end
      pida_pkg::CMD_REPLACE: begin
        if (p < shadow_count) shadow_list[p] = val[pida_pkg::ELEMENT_BITS-1:0];
        else r.status = pida_pkg::ST_RANGE;
      end
      pida_pkg::CMD_INSERT: begin
        if (p > shadow_count) r.status = pida_pkg::ST_RANGE;
        else if (shadow_count >= pida_pkg::CAPACITY) r.status = pida_pkg::ST_FULL;
        else begin
          for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = val[pida_pkg::ELEMENT_BITS-1:0];
          shadow_count++;
        end
      end
      pida_pkg::CMD_APPEND: begin
        if (shadow_count >= pida_pkg::CAPACITY) r.status = pida_pkg::ST_FULL;
        else begin
          shadow_list[shadow_count] = val[pida_pkg::ELEMENT_BITS-1:0];
          shadow_count++;
        end
      end
      pida_pkg::CMD_DELETE: begin
        if (p < shadow_count) begin
          for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end else r.status = pida_pkg::ST_RANGE;
      end
      default: ;
    endcase
    r.length = shadow_count[pida_pkg::CNT_BITS-1:0];
    pending_results.push_back(r);
  endtask

  task automatic issue_command(input logic [pida_pkg::CMD_BITS-1:0] cmd,
                               input logic [pida_pkg::POS_BITS-1:0] pos,
                               input logic [pida_pkg::VALUE_BITS-1:0] val);
    int unsigned gap;
    gap = $urandom_range(gap_max, 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_shadow_list(cmd, pos, val);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: value=%h length=%0d status=%0d",
                             out_read_value, out_length, out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_length !== want.length ||
            out_status !== want.status) begin
          note_error($sformatf({"mismatch: expected value=%h length=%0d status=%0d, ",
                                "got value=%h length=%0d status=%0d"},
                               want.read_value, want.length, want.status,
                               out_read_value, out_length, out_status));
        end
      end
    end
  end

  task automatic test_empty_and_small_list;
    issue_command(pida_pkg::CMD_READ, '0, '0);
    issue_command(pida_pkg::CMD_REPLACE, '0, VAL_ONES);
    issue_command(pida_pkg::CMD_DELETE, '0, '0);
    issue_command(pida_pkg::CMD_INSERT, 7'd1, 32'h1234_5678);
    issue_command(pida_pkg::CMD_APPEND, POS_TOP, VAL_ONES);
    issue_command(pida_pkg::CMD_READ, '0, '0);
    issue_command(CMD_UNUSED_A, POS_TOP, VAL_ONES);
    issue_command(CMD_UNUSED_B, '0, '0);
    issue_command(CMD_UNUSED_C, 7'd1, 32'hA5A5_5A5A);
    issue_command(pida_pkg::CMD_INSERT, '0, '0);
    issue_command(pida_pkg::CMD_INSERT, 7'd2, 32'h8000_0001);
    issue_command(pida_pkg::CMD_INSERT, 7'd1, 32'h0F0F_F0F0);
    issue_command(pida_pkg::CMD_READ, '0, '0);
    issue_command(pida_pkg::CMD_READ, 7'd1, '0);
    issue_command(pida_pkg::CMD_READ, 7'd2, '0);
    issue_command(pida_pkg::CMD_READ, 7'd3, '0);
    issue_command(pida_pkg::CMD_REPLACE, 7'd3, VAL_ONES);
    issue_command(pida_pkg::CMD_REPLACE, 7'd2, VAL_ONES);
    issue_command(pida_pkg::CMD_DELETE, 7'd1, '0);
    issue_command(pida_pkg::CMD_READ, 7'd1, '0);
    issue_command(pida_pkg::CMD_DELETE, 7'd3, '0);
    issue_command(pida_pkg::CMD_DELETE, '0, '0);
    issue_command(pida_pkg::CMD_READ, POS_TOP, '0);
  endtask

  task automatic test_full_list;
    while (shadow_count < pida_pkg::CAPACITY)
      issue_command(pida_pkg::CMD_APPEND, 7'($urandom), $urandom);
    issue_command(pida_pkg::CMD_APPEND, '0, 32'hDEAD_0001);
    issue_command(pida_pkg::CMD_INSERT, 7'(pida_pkg::CAPACITY), 32'hDEAD_0002);
    issue_command(pida_pkg::CMD_INSERT, 7'(pida_pkg::CAPACITY + 1), 32'hDEAD_0003);
    issue_command(pida_pkg::CMD_INSERT, '0, 32'hDEAD_0004);
    issue_command(pida_pkg::CMD_READ, 7'(pida_pkg::CAPACITY - 1), '0);
    issue_command(pida_pkg::CMD_READ, 7'(pida_pkg::CAPACITY), '0);
    issue_command(pida_pkg::CMD_REPLACE, 7'(pida_pkg::CAPACITY - 1), '0);
    issue_command(pida_pkg::CMD_DELETE, '0, '0);
    issue_command(pida_pkg::CMD_INSERT, 7'(pida_pkg::CAPACITY - 1), VAL_ONES);
    issue_command(pida_pkg::CMD_READ, 7'(pida_pkg::CAPACITY - 1), '0);
    issue_command(pida_pkg::CMD_DELETE, 7'(pida_pkg::CAPACITY), '0);
    issue_command(pida_pkg::CMD_DELETE, 7'(pida_pkg::CAPACITY - 1), '0);
  endtask

  task automatic test_random_mix;
    bit                              growing;
    int unsigned                     pick;
    logic [pida_pkg::CMD_BITS-1:0]   cmd;
    logic [pida_pkg::POS_BITS-1:0]   pos;
    logic [pida_pkg::VALUE_BITS-1:0] val;
    growing = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) gap_max = ((n / BLOCK_ITEMS) % 2 == 0) ? 15 : 0;
      if (growing && shadow_count == pida_pkg::CAPACITY && $urandom_range(3, 0) == 0)
        growing = 1'b0;
      if (!growing && shadow_count == 0 && $urandom_range(3, 0) == 0) growing = 1'b1;
      pick = $urandom_range(99, 0);
      if (pick < 20) cmd = pida_pkg::CMD_READ;
      else if (pick < 35) cmd = pida_pkg::CMD_REPLACE;
      else if (pick < 95) begin
        pick = $urandom_range(59, 0);
        if (growing)
          cmd = (pick < 25) ? pida_pkg::CMD_INSERT :
                (pick < 45) ? pida_pkg::CMD_APPEND : pida_pkg::CMD_DELETE;
        else
          cmd = (pick < 10) ? pida_pkg::CMD_INSERT :
                (pick < 20) ? pida_pkg::CMD_APPEND : pida_pkg::CMD_DELETE;
      end else begin
        case ($urandom_range(2, 0))
          0: cmd = CMD_UNUSED_A;
          1: cmd = CMD_UNUSED_B;
          default: cmd = CMD_UNUSED_C;
        endcase
      end
      case ($urandom_range(9, 0))
        0: pos = 7'($urandom);
        1: pos = 7'(shadow_count);
        2: pos = 7'(shadow_count + 1);
        default: begin
          if (cmd == pida_pkg::CMD_INSERT) pos = 7'($urandom_range(shadow_count, 0));
          else if (shadow_count == 0) pos = '0;
          else pos = 7'($urandom_range(shadow_count - 1, 0));
        end
      endcase
      case ($urandom_range(9, 0))
        0: val = '0;
        1: val = VAL_ONES;
        default: val = $urandom;
      endcase
      issue_command(cmd, pos, val);
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_small_list();
    test_full_list();
    test_random_mix();
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("positional_insert_delete_array_top_test: done, clean");
    end else begin
      $display("positional_insert_delete_array_top_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/pida_pkg.sv
src/pida_cell.sv
src/pida_ctrl.sv
src/positional_insert_delete_array_top.sv
bench/positional_insert_delete_array_top_test.sv
